### hdl/hfh_pkg.sv
package hfh_pkg;

  localparam int MAX_REPORT_BYTES  = 8;
  localparam int MAX_PAYLOAD_CHARS = 63;
  localparam int MOUSE_BYTES       = 4;
  localparam int STORE_DEPTH       = 8;

  localparam logic [7:0] START_BYTE   = 8'hAA;
  localparam logic [7:0] END_BYTE     = 8'h55;
  localparam logic [7:0] CMD_MOUSE    = 8'h01;
  localparam logic [7:0] CMD_KEYBOARD = 8'h02;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_PAYLOAD,
    PH_SPARE,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MOUSE   = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] data;
    logic        last;
  } hfh_res_t;

  // handshake between parser and result stage
  typedef struct packed {
    logic     emit;
    logic     kbd;
    hfh_res_t res;
  } hfh_emit_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

endpackage

### hdl/hfh_in_reg.sv
module hfh_in_reg
  import hfh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

### hdl/hfh_parser.sv
module hfh_parser
  import hfh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] b,
  output hfh_emit_t  em
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] held_r, held_nxt;
  logic       half_r, half_nxt;
  logic       stop_r, stop_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] store_r   [STORE_DEPTH];
  logic [7:0] store_nxt [STORE_DEPTH];
  logic [3:0] limit;
  logic [3:0] count_inc;
  logic [7:0] pair;
  logic [63:0] all_bytes;

  assign limit     = (cmd_r == CMD_MOUSE) ? 4'(MOUSE_BYTES) : 4'(MAX_REPORT_BYTES);
  assign count_inc = count_r + 4'd1;
  assign pair      = {hex_val(held_r), hex_val(b)};

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      all_bytes[i*8 +: 8] = store_r[i];
    end
  end

  // result for an end byte, independent of fire
  always_comb begin
    em.emit = (phase_r == PH_END) && (b == END_BYTE);
    em.kbd  = 1'b0;
    em.res  = '0;
    em.res.last = 1'b1;
    if (cmd_r == CMD_MOUSE) begin
      em.res.kind = KIND_MOUSE;
      em.res.data = {32'd0, all_bytes[31:0]};
    end else if (cmd_r == CMD_KEYBOARD) begin
      em.kbd      = 1'b1;
      em.res.kind = KIND_PRESS;
      em.res.data = all_bytes;
      em.res.last = 1'b0;
    end else begin
      em.res.kind = KIND_UNKNOWN;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    remain_nxt = remain_r;
    held_nxt   = held_r;
    half_nxt   = half_r;
    stop_nxt   = stop_r;
    count_nxt  = count_r;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (b > 8'(MAX_PAYLOAD_CHARS)) begin
            phase_nxt = PH_HUNT;
          end else begin
            remain_nxt = b;
            held_nxt   = '0;
            half_nxt   = 1'b0;
            stop_nxt   = 1'b0;
            count_nxt  = '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
              store_nxt[i] = '0;
            end
            phase_nxt = (b == 8'd0) ? PH_SPARE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (!stop_r) begin
            if (!half_r) begin
              if (b != SPACE_CHAR) begin
                if (is_hex(b)) begin
                  held_nxt = b;
                  half_nxt = 1'b1;
                end else begin
                  stop_nxt = 1'b1;
                end
              end
            end else begin
              half_nxt = 1'b0;
              if (!is_hex(b)) begin
                stop_nxt = 1'b1;
              end else begin
                for (int i = 0; i < STORE_DEPTH; i++) begin
                  if (count_r[2:0] == 3'(i)) begin
                    store_nxt[i] = pair;
                  end
                end
                count_nxt = count_inc;
                if (count_inc >= limit) begin
                  stop_nxt = 1'b1;
                end
              end
            end
          end
          remain_nxt = remain_r - 8'd1;
          if (remain_r == 8'd1) begin
            phase_nxt = PH_SPARE;
          end
        end
        PH_SPARE: begin
          phase_nxt = PH_END;
        end
        PH_END: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cmd_r    <= '0;
      remain_r <= '0;
      held_r   <= '0;
      half_r   <= 1'b0;
      stop_r   <= 1'b0;
      count_r  <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      remain_r <= remain_nxt;
      held_r   <= held_nxt;
      half_r   <= half_nxt;
      stop_r   <= stop_nxt;
      count_r  <= count_nxt;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

endmodule

### hdl/hfh_out_stage.sv
module hfh_out_stage
  import hfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  hfh_emit_t   em,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic     valid_r, valid_nxt;
  logic     pend_r, pend_nxt;
  hfh_res_t res_r, res_nxt;
  hfh_res_t release_res;

  always_comb begin
    release_res      = '0;
    release_res.kind = KIND_RELEASE;
    release_res.last = 1'b1;
  end

  assign free = !pend_r && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    res_nxt   = res_r;
    if (valid_r && out_tready) begin
      if (pend_r) begin
        res_nxt  = release_res;
        pend_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = em.res;
      pend_nxt  = em.kbd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.data;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

### hdl/hex_frame_to_hid_report.sv
// channel  dir  tdata                      tuser           tlast
// in_      in   [7:0] rx_byte              -               -
// out_     out  report_byte_0..7, 8 each   [1:0] report_kind last_of_run
//
// one byte per cycle sustained while the output stage can take results; a byte
// reaches the parser from the input register and a result is registered from its end byte
// a keyboard frame gives two results; the release follows the press
// synchronous active-low reset returns the parser to hunting for 0xAA
// an end byte waits in the input register while the result register is full
module hex_frame_to_hid_report
  import hfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // report_byte_0 .. report_byte_7
  output logic [1:0]  out_tuser,  // report_kind
  output logic        out_tlast   // last_of_run
);

  logic      byte_valid;
  logic [7:0] byte_data;
  logic      take;
  logic      free;
  hfh_emit_t em;

  assign take = byte_valid && (!em.emit || free);

  hfh_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  hfh_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .b     (byte_data),
    .em    (em)
  );

  hfh_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && em.emit),
    .em         (em),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
